@@ rtl/bce_pkg.sv @@
// bce_pkg: shared types and constants of the biquad cascade equalizer
// depends on nothing; imported by the sequencer, the MAC unit and the top level

package bce_pkg;

    // fixed widths of the data path
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int COEF_W    = 16;
    localparam int HIST_W    = 32;
    localparam int PROD_W    = COEF_W + HIST_W;
    localparam int ACC_W     = PROD_W + 4;
    localparam int FRAC_SH   = 14;
    localparam int PCM_SH    = 8;
    localparam int BAND_W    = 3;
    localparam int TERM_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND0  = 3'd1;
    localparam int                   COEF_REGS  = 5;

    // b0 = 1.0, everything else zero
    localparam logic [CFG_W-1:0] COEF_IDENTITY = 64'd16384;

    // product terms of one band step, in issue order
    localparam logic [TERM_W-1:0] TERM_B0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_B1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_B2 = 3'd2;
    localparam logic [TERM_W-1:0] TERM_A1 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_A2 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_WRITE,
        ST_DONE
    } state_t;

    // sequencer controls for the MAC unit and the history path
    typedef struct packed {
        logic              mac;
        logic              wr;
        logic              done;
        logic [TERM_W-1:0] term;
        logic [BAND_W-1:0] band;
    } seq_ctl_t;

endpackage

@@ rtl/bce_ifs.sv @@
// bce_ifs: valid/ready channel interfaces for samples in and equalized samples out
// depends on nothing

interface bce_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample_in;
    logic [2:0]        channel;
    logic              end_of_block;

    modport source (output valid, output sample_in, output channel, output end_of_block,
                     input ready);
    modport sink (input valid, input sample_in, input channel, input end_of_block,
                   output ready);
endinterface

interface bce_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample_out;
    logic [2:0]        channel_out;
    logic              end_of_block_out;

    modport source (output valid, output sample_out, output channel_out,
                     output end_of_block_out, input ready);
    modport sink (input valid, input sample_out, input channel_out,
                   input end_of_block_out, output ready);
endinterface

@@ rtl/biquad_cascade_equalizer.sv @@
// Five-band biquad equalizer: every band runs five multiply-accumulates on one shared MAC.
// Filtered word: the sequencer runs the MAC states and a write state for each band, then a done
// state that loads the output register; no new word is taken until it is back in idle.
// Passed-through word: goes straight to the done state. The done state waits for a free output.
// Reset sets enable to 1, coefficients to identity, and makes all history read as zero.

module biquad_cascade_equalizer
    import bce_pkg::*;
#(
    parameter int BANDS    = 5,
    parameter int CHANNELS = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bce_in_if.sink               audio,
    bce_out_if.source            equalized,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ROWS   = BANDS * CHANNELS;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int ROW_W  = 4 * HIST_W;

    seq_ctl_t ctl;
    logic     idle;
    logic     in_fire;
    logic     filt;
    logic     out_free;

    logic             enable_reg;
    logic [CFG_W-1:0] coef_reg [BANDS];

    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] k_reg;
    logic [ROW_W-1:0]  rd_data;
    logic [ROW_W-1:0]  wr_data;
    logic [ROWS-1:0]   row_valid_reg;
    logic              rd_valid_reg;

    logic signed [HIST_W-1:0] hx1, hx2, hy1, hy2;
    logic signed [HIST_W-1:0] x_reg;
    logic signed [HIST_W-1:0] y;
    logic [CHAN_W-1:0]        ch_reg;
    logic                     eob_reg;

    logic [CFG_W-1:0]         coef_word;
    logic signed [COEF_W-1:0] coef;
    logic signed [HIST_W-1:0] operand;

    logic signed [HIST_W:0]     adj;
    logic signed [HIST_W:0]     q;
    logic signed [SAMPLE_W-1:0] q_clip;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic [CHAN_W-1:0]          channel_out_reg;
    logic                       eob_out_reg;

    // input handshake and routing decision
    assign audio.ready = idle;
    assign in_fire     = audio.valid && idle;
    assign filt        = enable_reg && ({1'b0, audio.channel} < (CHAN_W + 1)'(CHANNELS));
    assign out_free    = !out_valid_reg || equalized.ready;

    bce_seq #(
        .BANDS (BANDS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .filt     (filt),
        .out_free (out_free),
        .idle     (idle),
        .ctl      (ctl)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
        end
        else if (cfg_we && (cfg_index == REG_ENABLE))
        begin
            enable_reg <= cfg_data[0];
        end
    end

    for (genvar b = 0; b < BANDS; b++)
    begin : g_coef
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[b] <= COEF_IDENTITY;
            end
            else if (cfg_we && (b < COEF_REGS)
                     && (cfg_index == REG_BAND0 + CFG_IDX_W'(b)))
            begin
                coef_reg[b] <= cfg_data;
            end
        end
    end

    // history row address: first band of the channel, then one row per band
    assign base_addr = ADDR_W'(int'(audio.channel) * BANDS);

    always_comb
    begin
        if (idle)
        begin
            rd_addr = base_addr;
        end
        else if (ctl.wr)
        begin
            rd_addr = k_reg + ADDR_W'(1);
        end
        else
        begin
            rd_addr = k_reg;
        end
    end

    bce_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_hist (
        .clk     (clk),
        .we      (ctl.wr),
        .wr_addr (k_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // row valid bits stand in for the cleared history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.wr)
            begin
                row_valid_reg[k_reg] <= 1'b1;
            end
            rd_valid_reg <= ({1'b0, rd_addr} < (ADDR_W + 1)'(ROWS)) ? row_valid_reg[rd_addr]
                                                                   : 1'b0;
        end
    end

    // unpack history, never written rows read as zero
    always_comb
    begin
        hx1 = rd_valid_reg ? rd_data[HIST_W-1:0]            : '0;
        hx2 = rd_valid_reg ? rd_data[2*HIST_W-1:HIST_W]     : '0;
        hy1 = rd_valid_reg ? rd_data[3*HIST_W-1:2*HIST_W]   : '0;
        hy2 = rd_valid_reg ? rd_data[4*HIST_W-1:3*HIST_W]   : '0;
        wr_data = {hy1, y, hx1, x_reg};
    end

    // coefficient and operand for the current term
    assign coef_word = coef_reg[ctl.band[BIDX_W-1:0]];

    always_comb
    begin
        case (ctl.term) inside
            TERM_B0:
            begin
                coef    = coef_word[15:0];
                operand = x_reg;
            end
            TERM_B1, TERM_A1:
            begin
                coef    = coef_word[31:16];
                operand = (ctl.term == TERM_B1) ? hx1 : hy1;
            end
            TERM_B2:
            begin
                coef    = coef_word[47:32];
                operand = hx2;
            end
            TERM_A2:
            begin
                coef    = coef_word[63:48];
                operand = hy2;
            end
            default:
            begin
                coef    = '0;
                operand = '0;
            end
        endcase
    end

    bce_mac u_mac (
        .clk     (clk),
        .ctl     (ctl),
        .coef    (coef),
        .operand (operand),
        .y       (y)
    );

    // working sample and row pointer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= HIST_W'(audio.sample_in) <<< PCM_SH;
            k_reg   <= base_addr;
            ch_reg  <= audio.channel;
            eob_reg <= audio.end_of_block;
        end
        else if (ctl.wr)
        begin
            x_reg <= y;
            k_reg <= k_reg + ADDR_W'(1);
        end
    end

    // back to a PCM sample: truncate toward zero, clip to 16 bits
    always_comb
    begin
        adj = (HIST_W + 1)'(x_reg) + (x_reg[HIST_W-1] ? (HIST_W + 1)'(255) : '0);
        q   = adj >>> PCM_SH;
        if (q > (HIST_W + 1)'(32767))
        begin
            q_clip = 16'sh7FFF;
        end
        else if (q < -(HIST_W + 1)'(32768))
        begin
            q_clip = 16'sh8000;
        end
        else
        begin
            q_clip = q[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (equalized.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done && out_free)
        begin
            sample_out_reg  <= q_clip;
            channel_out_reg <= ch_reg;
            eob_out_reg     <= eob_reg;
        end
    end

    assign equalized.valid            = out_valid_reg;
    assign equalized.sample_out       = sample_out_reg;
    assign equalized.channel_out      = channel_out_reg;
    assign equalized.end_of_block_out = eob_out_reg;

endmodule

@@ rtl/bce_ram.sv @@
// bce_ram: generic single write port, single read port RAM with registered read
// depends on nothing

module bce_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 10
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/bce_seq.sv @@
// bce_seq: sequencer that walks the bands and product terms of one sample
// depends on bce_pkg

module bce_seq
    import bce_pkg::*;
#(
    parameter int BANDS = 5
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     filt,
    input  logic     out_free,
    output logic     idle,
    output seq_ctl_t ctl
);

    state_t            state_reg, state_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              last_band;

    assign last_band = (band_reg == BAND_W'(BANDS - 1));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_B0;
            band_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            band_reg  <= band_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        band_next  = band_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = filt ? ST_MAC : ST_DONE;
                    term_next  = TERM_B0;
                    band_next  = '0;
                end
            end
            ST_MAC:
            begin
                term_next = term_reg + TERM_W'(1);
                if (term_reg == TERM_A2)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (last_band)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MAC;
                    term_next  = TERM_B0;
                    band_next  = band_reg + BAND_W'(1);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle     = (state_reg == ST_IDLE);
        ctl.mac  = (state_reg == ST_MAC);
        ctl.wr   = (state_reg == ST_WRITE);
        ctl.done = (state_reg == ST_DONE);
        ctl.term = term_reg;
        ctl.band = band_reg;
    end

endmodule

@@ rtl/bce_mac.sv @@
// bce_mac: shared 16x32 multiplier and accumulator for the biquad terms
// depends on bce_pkg; gives the saturated Q23.8 band output in the write cycle

module bce_mac
    import bce_pkg::*;
(
    input  logic                     clk,
    input  seq_ctl_t                 ctl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [HIST_W-1:0] operand,
    output logic signed [HIST_W-1:0] y
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sub_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  shifted;

    // multiply stage, feedback terms are subtracted
    always_ff @(posedge clk)
    begin
        prod_reg <= coef * operand;
        sub_reg  <= (ctl.term >= TERM_A1);
    end

    // signed addend and running sum
    always_comb
    begin
        addend   = sub_reg ? -ACC_W'(prod_reg) : ACC_W'(prod_reg);
        sum      = ((ctl.term == TERM_B1) ? '0 : acc_reg) + addend;
        acc_next = ctl.mac ? sum : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // floor shift back to Q23.8 and saturate to 32 bits
    always_comb
    begin
        shifted = sum >>> FRAC_SH;
        if ((&shifted[ACC_W-1:HIST_W-1]) || !(|shifted[ACC_W-1:HIST_W-1]))
        begin
            y = shifted[HIST_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            y = {1'b1, {(HIST_W-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(HIST_W-1){1'b1}}};
        end
    end

endmodule

@@ rtl/bce_checker.sv @@
// bce_assertions: port-level assertions for the equalizer, bound to the top level
// depends on biquad_cascade_equalizer and its channel interfaces

module bce_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] sample_out,
    input logic [2:0]  channel_out,
    input logic        eob_out
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] pending_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_fire) - 3'(out_fire);
        end
    end

    // one word in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken again while a word is in work");

    // no result without an accepted word
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 3'd0))
        else $error("result shown with no word outstanding");

    // at most one word in work and one waiting at the output
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more words outstanding than the block can hold");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
                                    && $stable(channel_out) && $stable(eob_out))
        else $error("stalled result changed or dropped");

endmodule

bind biquad_cascade_equalizer bce_assertions u_bce_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (audio.valid),
    .in_ready    (audio.ready),
    .out_valid   (equalized.valid),
    .out_ready   (equalized.ready),
    .sample_out  (equalized.sample_out),
    .channel_out (equalized.channel_out),
    .eob_out     (equalized.end_of_block_out)
);
